// ===== rtl/core/lcdfw_pkg.sv =====
// Shared types, constants and the sequencer microcode for the LCD expander frame writer.
// No dependencies; used by every file under rtl/core.
package lcdfw_pkg;

    localparam int MAX_ROWS_DEF    = 4;
    localparam int MAX_COLUMNS_DEF = 20;

    localparam int NUM_W    = 32;
    localparam int DIGITS   = 10;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int BITCNT_W = $clog2(NUM_W);
    localparam int DIGCNT_W = $clog2(DIGITS + 1);
    localparam int SEQ_LEN  = 7;
    localparam int SEQ_W    = $clog2(SEQ_LEN);

    localparam logic [2:0] CMD_PRINT_CHAR = 3'd0;
    localparam logic [2:0] CMD_SET_CURSOR = 3'd1;
    localparam logic [2:0] CMD_CLEAR      = 3'd2;
    localparam logic [2:0] CMD_PRINT_INT  = 3'd3;
    localparam logic [2:0] CMD_POWER_UP   = 3'd4;

    localparam logic [1:0] CFG_BACKLIGHT = 2'd0;
    localparam logic [1:0] CFG_ROWS      = 2'd1;
    localparam logic [1:0] CFG_COLUMNS   = 2'd2;

    localparam int CFG_W = 5;

    localparam logic [7:0] BYTE_CLEAR  = 8'h01;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;

    typedef logic [3:0] step_t;

    localparam step_t S_WAIT      = 4'd0;
    localparam step_t S_CHAR      = 4'd1;
    localparam step_t S_CURSOR    = 4'd2;
    localparam step_t S_CLEAR     = 4'd3;
    localparam step_t S_SEND_ONE  = 4'd4;
    localparam step_t S_NUM_INIT  = 4'd5;
    localparam step_t S_DABBLE    = 4'd6;
    localparam step_t S_STRIP     = 4'd7;
    localparam step_t S_DIGIT     = 4'd8;
    localparam step_t S_SEND_DIG  = 4'd9;
    localparam step_t S_SEQ_INIT  = 4'd10;
    localparam step_t S_SEQ       = 4'd11;
    localparam step_t S_SEND_SEQ  = 4'd12;

    typedef enum logic [3:0] {
        OP_WAIT,
        OP_LOAD_CHAR,
        OP_LOAD_CURSOR,
        OP_LOAD_CLEAR,
        OP_SEND,
        OP_NUM_INIT,
        OP_DABBLE,
        OP_STRIP,
        OP_LOAD_DIGIT,
        OP_SEQ_INIT,
        OP_LOAD_SEQ
    } op_t;

    typedef enum logic [1:0] {
        LAST_ONE,
        LAST_DIGIT,
        LAST_SEQ
    } last_sel_t;

    typedef struct packed {
        op_t       op;
        last_sel_t last_sel;
        step_t     next;
    } uword_t;

    typedef struct packed {
        logic load;
        logic dabble;
        logic shift;
    } dig_ctl_t;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [7:0]       char_code;
        logic [1:0]       row;
        logic [4:0]       column;
        logic [NUM_W-1:0] number;
    } in_item_t;

    typedef struct packed {
        logic [7:0] expander_byte;
        logic       last;
    } out_item_t;

    function automatic uword_t ucode(input step_t s);
        uword_t w;
        case (s)
            S_WAIT:     w = '{OP_WAIT,        LAST_ONE,   S_WAIT};
            S_CHAR:     w = '{OP_LOAD_CHAR,   LAST_ONE,   S_SEND_ONE};
            S_CURSOR:   w = '{OP_LOAD_CURSOR, LAST_ONE,   S_SEND_ONE};
            S_CLEAR:    w = '{OP_LOAD_CLEAR,  LAST_ONE,   S_SEND_ONE};
            S_SEND_ONE: w = '{OP_SEND,        LAST_ONE,   S_WAIT};
            S_NUM_INIT: w = '{OP_NUM_INIT,    LAST_ONE,   S_DABBLE};
            S_DABBLE:   w = '{OP_DABBLE,      LAST_ONE,   S_STRIP};
            S_STRIP:    w = '{OP_STRIP,       LAST_ONE,   S_DIGIT};
            S_DIGIT:    w = '{OP_LOAD_DIGIT,  LAST_ONE,   S_SEND_DIG};
            S_SEND_DIG: w = '{OP_SEND,        LAST_DIGIT, S_DIGIT};
            S_SEQ_INIT: w = '{OP_SEQ_INIT,    LAST_ONE,   S_SEQ};
            S_SEQ:      w = '{OP_LOAD_SEQ,    LAST_ONE,   S_SEND_SEQ};
            S_SEND_SEQ: w = '{OP_SEND,        LAST_SEQ,   S_SEQ};
            default:    w = '{OP_WAIT,        LAST_ONE,   S_WAIT};
        endcase
        return w;
    endfunction

    function automatic step_t dispatch(input logic [2:0] cmd);
        step_t s;
        case (cmd)
            CMD_PRINT_CHAR: s = S_CHAR;
            CMD_SET_CURSOR: s = S_CURSOR;
            CMD_CLEAR:      s = S_CLEAR;
            CMD_PRINT_INT:  s = S_NUM_INIT;
            CMD_POWER_UP:   s = S_SEQ_INIT;
            default:        s = S_WAIT;
        endcase
        return s;
    endfunction

    function automatic logic [6:0] row_base(input logic [1:0] row);
        logic [6:0] b;
        case (row)
            2'd0:    b = 7'h00;
            2'd1:    b = 7'h40;
            2'd2:    b = 7'h14;
            default: b = 7'h54;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] power_seq(input logic [SEQ_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h03;
            3'd1:    b = 8'h03;
            3'd2:    b = 8'h02;
            3'd3:    b = 8'h28;
            3'd4:    b = 8'h01;
            3'd5:    b = 8'h0C;
            3'd6:    b = 8'h06;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/lcdfw_digits.sv =====
// Binary to BCD digit unit: one shift-add-3 step per cycle, then digit shifts MSD first.
// Depends on lcdfw_pkg.
module lcdfw_digits
(
    input  logic                          clk,
    input  lcdfw_pkg::dig_ctl_t           ctl,
    input  logic [lcdfw_pkg::NUM_W-1:0]   number,
    output logic [3:0]                    top_digit
);

    logic [lcdfw_pkg::NUM_W-1:0] bin_reg;
    logic [lcdfw_pkg::NUM_W-1:0] bin_next;
    logic [lcdfw_pkg::BCD_W-1:0] bcd_reg;
    logic [lcdfw_pkg::BCD_W-1:0] bcd_next;
    logic [lcdfw_pkg::BCD_W-1:0] bcd_adj;

    always_comb
    begin
        logic [3:0] d;
        d = 4'd0;
        for (int i = 0; i < lcdfw_pkg::DIGITS; i++)
        begin
            d = bcd_reg[i*4 +: 4];
            bcd_adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (ctl.load)
        begin
            bin_next = number;
            bcd_next = '0;
        end
        else if (ctl.dabble)
        begin
            bin_next = {bin_reg[lcdfw_pkg::NUM_W-2:0], 1'b0};
            bcd_next = {bcd_adj[lcdfw_pkg::BCD_W-2:0], bin_reg[lcdfw_pkg::NUM_W-1]};
        end
        else if (ctl.shift)
        begin
            bcd_next = {bcd_reg[lcdfw_pkg::BCD_W-5:0], 4'h0};
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[lcdfw_pkg::BCD_W-1 -: 4];

endmodule

// ===== rtl/core/char_lcd_expander_frame_writer.sv =====
// Top level of the character-LCD expander frame writer: microcode sequencer and frame datapath.
// Depends on lcdfw_pkg and lcdfw_digits.
//
//   channel   direction  signals                         beat
//   in        sink       in_valid, in_ready, in_data     one LCD request
//   out       source     out_valid, out_ready, out_data  one expander frame
//   cfg       sink       cfg_we, cfg_index, cfg_data     one register write
//
// A request is taken only in the wait step; each LCD byte costs one load step plus four frames.
// Print char, clear, set cursor: one byte (none for a cursor out of range); power-up: 7 bytes;
// print integer: init, 32 conversion steps, 1 to 9 zero-strip steps, one byte per digit.
// The frame output register lets the next request in while the final frame still waits.
// A stalled out channel holds the sequencer in its send step. Datapath registers have no reset.
module char_lcd_expander_frame_writer
#(
    parameter int MAX_ROWS    = lcdfw_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = lcdfw_pkg::MAX_COLUMNS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lcdfw_pkg::in_item_t           in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output lcdfw_pkg::out_item_t          out_data,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [lcdfw_pkg::CFG_W-1:0]   cfg_data
);

    lcdfw_pkg::step_t     step_reg;
    lcdfw_pkg::step_t     step_next;
    lcdfw_pkg::uword_t    uw;
    lcdfw_pkg::in_item_t  item_reg;
    lcdfw_pkg::out_item_t out_data_reg;
    lcdfw_pkg::out_item_t out_data_next;
    lcdfw_pkg::dig_ctl_t  dig_ctl;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [1:0]                      phase_reg;
    logic [1:0]                      phase_next;
    logic [7:0]                      byte_reg;
    logic [7:0]                      byte_next;
    logic                            rs_reg;
    logic                            rs_next;
    logic [lcdfw_pkg::BITCNT_W-1:0]  bit_cnt_reg;
    logic [lcdfw_pkg::BITCNT_W-1:0]  bit_cnt_next;
    logic [lcdfw_pkg::DIGCNT_W-1:0]  dig_cnt_reg;
    logic [lcdfw_pkg::DIGCNT_W-1:0]  dig_cnt_next;
    logic [lcdfw_pkg::SEQ_W-1:0]     seq_idx_reg;
    logic [lcdfw_pkg::SEQ_W-1:0]     seq_idx_next;
    logic                            backlight_reg;
    logic [2:0]                      rows_reg;
    logic [4:0]                      columns_reg;

    logic       in_fire;
    logic       can_load;
    logic       send_load;
    logic       byte_done;
    logic       end_cond;
    logic       cursor_ok;
    logic       strip_go;
    logic [3:0] top_digit;
    logic [3:0] nibble;
    logic [6:0] cursor_addr;

    assign uw        = lcdfw_pkg::ucode(step_reg);
    assign in_ready  = (uw.op == lcdfw_pkg::OP_WAIT);
    assign in_fire   = in_valid && in_ready;
    assign can_load  = !out_valid_reg || out_ready;
    assign send_load = (uw.op == lcdfw_pkg::OP_SEND) && can_load;
    assign byte_done = send_load && (phase_reg == 2'd3);

    assign cursor_ok = ({1'b0, item_reg.row} < rows_reg)
                    && ({1'b0, item_reg.row} < 3'(MAX_ROWS))
                    && (item_reg.column < columns_reg)
                    && (item_reg.column < 5'(MAX_COLUMNS));
    assign cursor_addr = 7'(lcdfw_pkg::row_base(item_reg.row) + {2'b00, item_reg.column});

    assign strip_go = (top_digit == 4'd0) && (dig_cnt_reg > 4'd2);

    always_comb
    begin
        case (uw.last_sel)
            lcdfw_pkg::LAST_ONE:   end_cond = 1'b1;
            lcdfw_pkg::LAST_DIGIT: end_cond = (dig_cnt_reg == 4'd1);
            lcdfw_pkg::LAST_SEQ:   end_cond = (seq_idx_reg == 3'(lcdfw_pkg::SEQ_LEN - 1));
            default:               end_cond = 1'b1;
        endcase
    end

    // next step
    always_comb
    begin
        step_next = step_reg;
        case (uw.op)
            lcdfw_pkg::OP_WAIT:
            begin
                if (in_fire)
                begin
                    step_next = lcdfw_pkg::dispatch(in_data.cmd);
                end
            end
            lcdfw_pkg::OP_LOAD_CURSOR:
            begin
                step_next = cursor_ok ? uw.next : lcdfw_pkg::S_WAIT;
            end
            lcdfw_pkg::OP_DABBLE:
            begin
                step_next = (bit_cnt_reg == '0) ? uw.next : step_reg;
            end
            lcdfw_pkg::OP_STRIP:
            begin
                step_next = strip_go ? step_reg : uw.next;
            end
            lcdfw_pkg::OP_SEND:
            begin
                if (byte_done)
                begin
                    step_next = end_cond ? lcdfw_pkg::S_WAIT : uw.next;
                end
            end
            default:
            begin
                step_next = uw.next;
            end
        endcase
    end

    // datapath controls
    always_comb
    begin
        byte_next    = byte_reg;
        rs_next      = rs_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        seq_idx_next = seq_idx_reg;
        phase_next   = phase_reg;
        dig_ctl      = '0;
        case (uw.op)
            lcdfw_pkg::OP_LOAD_CHAR:
            begin
                byte_next = item_reg.char_code;
                rs_next   = 1'b1;
            end
            lcdfw_pkg::OP_LOAD_CURSOR:
            begin
                byte_next = {1'b1, cursor_addr};
                rs_next   = 1'b0;
            end
            lcdfw_pkg::OP_LOAD_CLEAR:
            begin
                byte_next = lcdfw_pkg::BYTE_CLEAR;
                rs_next   = 1'b0;
            end
            lcdfw_pkg::OP_NUM_INIT:
            begin
                dig_ctl.load = 1'b1;
                bit_cnt_next = lcdfw_pkg::BITCNT_W'(lcdfw_pkg::NUM_W - 1);
                dig_cnt_next = lcdfw_pkg::DIGCNT_W'(lcdfw_pkg::DIGITS);
            end
            lcdfw_pkg::OP_DABBLE:
            begin
                dig_ctl.dabble = 1'b1;
                bit_cnt_next   = bit_cnt_reg - lcdfw_pkg::BITCNT_W'(1);
            end
            lcdfw_pkg::OP_STRIP:
            begin
                if (strip_go)
                begin
                    dig_ctl.shift = 1'b1;
                    dig_cnt_next  = dig_cnt_reg - lcdfw_pkg::DIGCNT_W'(1);
                end
            end
            lcdfw_pkg::OP_LOAD_DIGIT:
            begin
                byte_next = lcdfw_pkg::ASCII_ZERO | {4'h0, top_digit};
                rs_next   = 1'b1;
            end
            lcdfw_pkg::OP_SEQ_INIT:
            begin
                seq_idx_next = '0;
            end
            lcdfw_pkg::OP_LOAD_SEQ:
            begin
                byte_next = lcdfw_pkg::power_seq(seq_idx_reg);
                rs_next   = 1'b0;
            end
            lcdfw_pkg::OP_SEND:
            begin
                if (send_load)
                begin
                    phase_next = phase_reg + 2'd1;
                end
                if (byte_done && (uw.last_sel == lcdfw_pkg::LAST_DIGIT))
                begin
                    dig_ctl.shift = 1'b1;
                    dig_cnt_next  = dig_cnt_reg - lcdfw_pkg::DIGCNT_W'(1);
                end
                if (byte_done && (uw.last_sel == lcdfw_pkg::LAST_SEQ))
                begin
                    seq_idx_next = seq_idx_reg + lcdfw_pkg::SEQ_W'(1);
                end
            end
            default:
            begin
                phase_next = 2'd0;
            end
        endcase
    end

    assign nibble = phase_reg[1] ? byte_reg[3:0] : byte_reg[7:4];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (send_load)
        begin
            out_valid_next              = 1'b1;
            out_data_next.expander_byte = {nibble, backlight_reg, ~phase_reg[0], 1'b0, rs_reg};
            out_data_next.last          = (phase_reg == 2'd3) && end_cond;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= lcdfw_pkg::S_WAIT;
            out_valid_reg <= 1'b0;
            phase_reg     <= 2'd0;
            backlight_reg <= 1'b1;
            rows_reg      <= 3'd2;
            columns_reg   <= 5'd16;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    lcdfw_pkg::CFG_BACKLIGHT: backlight_reg <= cfg_data[0];
                    lcdfw_pkg::CFG_ROWS:      rows_reg      <= cfg_data[2:0];
                    lcdfw_pkg::CFG_COLUMNS:   columns_reg   <= cfg_data[4:0];
                    default:                  columns_reg   <= columns_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_data;
        end
        out_data_reg <= out_data_next;
        byte_reg     <= byte_next;
        rs_reg       <= rs_next;
        bit_cnt_reg  <= bit_cnt_next;
        dig_cnt_reg  <= dig_cnt_next;
        seq_idx_reg  <= seq_idx_next;
    end

    lcdfw_digits u_digits
    (
        .clk       (clk),
        .ctl       (dig_ctl),
        .number    (item_reg.number),
        .top_digit (top_digit)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/core/lcdfw_checker.sv =====
// Port-level checks for the LCD expander frame writer, bound to the top level.
// Depends on lcdfw_pkg and char_lcd_expander_frame_writer.
module lcdfw_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input lcdfw_pkg::in_item_t           in_data,
    input logic                          out_valid,
    input logic                          out_ready,
    input lcdfw_pkg::out_item_t          out_data
);

    // hold a stalled beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("out beat changed while stalled");

    // an EN-high frame is followed at once by its EN-low twin
    a_en_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.expander_byte[2]
        |=> out_valid && !out_data.expander_byte[2]
            && (out_data.expander_byte[7:4] == $past(out_data.expander_byte[7:4]))
            && (out_data.expander_byte[0] == $past(out_data.expander_byte[0])))
        else $error("EN pulse not closed by matching frame");

    a_last_en_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last |-> !out_data.expander_byte[2] && !out_data.expander_byte[1])
        else $error("final frame with EN or RW set");

    a_busy_after_char: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.cmd == lcdfw_pkg::CMD_PRINT_CHAR) |=> !in_ready)
        else $error("request taken while a character is pending");

endmodule

bind char_lcd_expander_frame_writer lcdfw_checker u_lcdfw_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
